// ===== src/pfcp_pkg.sv =====
package pfcp_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_MAP
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;      // load item, read page table entry
        logic clr_step;    // clear one page table entry
        logic hit_upd;     // hit: set used, dirty on write, post result
        logic map_fill;    // fault into lowest free frame, post result
        logic sweep_rd;    // read frame state at the hand
        logic sweep_skip;  // clear used at hand, advance, read next frame
        logic evict;       // unmap the victim page, latch victim info
        logic map_victim;  // map into the victim frame, post result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_valid;    // input item offered
        logic clr_last;    // clearing the last page table entry
        logic present;     // looked-up page is resident
        logic full;        // no free frame left
        logic used;        // used bit of frame under the hand
        logic out_free;    // result register can take a result
    } t_stat;

    localparam int OutWidth = 48;

endpackage

// ===== src/pfcp_ctrl.sv =====
module pfcp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfcp_pkg::t_stat i_stat,
    output pfcp_pkg::t_cmd  o_cmd,
    output logic           o_ready
);

    pfcp_pkg::t_state r_state;
    pfcp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfcp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            pfcp_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = pfcp_pkg::ST_IDLE;
                end
            end
            pfcp_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = pfcp_pkg::ST_LOOKUP;
                end
            end
            pfcp_pkg::ST_LOOKUP: begin
                priority if (i_stat.present) begin
                    if (i_stat.out_free) begin
                        o_cmd.hit_upd = 1'b1;
                        n_state       = pfcp_pkg::ST_IDLE;
                    end
                end else if (!i_stat.full) begin
                    if (i_stat.out_free) begin
                        o_cmd.map_fill = 1'b1;
                        n_state        = pfcp_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.sweep_rd = 1'b1;
                    n_state        = pfcp_pkg::ST_SWEEP;
                end
            end
            pfcp_pkg::ST_SWEEP: begin
                if (i_stat.used) begin
                    o_cmd.sweep_skip = 1'b1;
                end else begin
                    o_cmd.evict = 1'b1;
                    n_state     = pfcp_pkg::ST_MAP;
                end
            end
            pfcp_pkg::ST_MAP: begin
                if (i_stat.out_free) begin
                    o_cmd.map_victim = 1'b1;
                    n_state          = pfcp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfcp_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/pfcp_datapath.sv =====
module pfcp_datapath #(
    parameter int NUM_PAGES  = 256,
    parameter int NUM_FRAMES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfcp_pkg::t_cmd                 i_cmd,
    output pfcp_pkg::t_stat                o_stat,
    input  logic                          i_s_tvalid,
    input  logic [7:0]                    i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pfcp_pkg::OutWidth-1:0] o_m_tdata
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    // page table: {present, frame}
    logic [FW:0]   r_pte_mem [NUM_PAGES];
    logic [PW-1:0] r_owner_mem [NUM_FRAMES];
    logic          r_used_mem [NUM_FRAMES];
    logic          r_dirty_mem [NUM_FRAMES];

    logic [PW-1:0] r_page;
    logic          r_func;
    logic [FW:0]   r_pte_rd;
    logic [PW-1:0] r_fr_owner;
    logic          r_fr_used;
    logic          r_fr_dirty;
    logic [PW-1:0] r_vic_page;
    logic          r_vic_wb;
    logic [CW-1:0] r_fill;
    logic [FW-1:0] r_hand;
    logic [31:0]   r_faults;
    logic [PW-1:0] r_clr;
    logic          r_out_valid;
    logic [pfcp_pkg::OutWidth-1:0] r_out_data;

    logic [7:0]    red_page;
    logic [PW-1:0] in_page;
    logic [FW-1:0] fill_frame;
    logic [FW-1:0] hand_inc;
    logic [FW-1:0] map_frame;
    logic          out_free;
    logic          do_map;
    logic          out_load;

    logic          pte_we;
    logic [PW-1:0] pte_waddr;
    logic [FW:0]   pte_wdata;
    logic [FW-1:0] fr_raddr;
    logic          fr_re;

    function automatic logic [FW-1:0] frame_inc(input logic [FW-1:0] f);
        logic [FW-1:0] res;
        if (f == FW'(NUM_FRAMES - 1)) begin
            res = '0;
        end else begin
            res = f + 1'b1;
        end
        return res;
    endfunction

    // page number modulo NUM_PAGES, restoring remainder over 8 bits
    always_comb begin
        red_page = i_s_tdata;
        for (int k = 7; k >= 0; k--) begin
            if ((NUM_PAGES << k) <= 255) begin
                if (red_page >= 8'(NUM_PAGES << k)) begin
                    red_page = red_page - 8'(NUM_PAGES << k);
                end
            end
        end
    end

    assign in_page    = PW'(red_page);
    assign fill_frame = FW'(r_fill);
    assign hand_inc   = frame_inc(r_hand);
    assign out_free   = !r_out_valid || i_m_tready;
    assign do_map     = i_cmd.map_fill || i_cmd.map_victim;
    assign out_load   = do_map || i_cmd.hit_upd;
    assign map_frame  = i_cmd.map_fill ? fill_frame : r_hand;

    always_comb begin
        pte_we    = 1'b1;
        pte_waddr = r_page;
        pte_wdata = {1'b1, map_frame};
        priority if (i_cmd.clr_step) begin
            pte_waddr = r_clr;
            pte_wdata = '0;
        end else if (i_cmd.evict) begin
            pte_waddr = r_fr_owner;
            pte_wdata = '0;
        end else if (do_map) begin
            pte_waddr = r_page;
        end else begin
            pte_we = 1'b0;
        end
    end

    assign fr_re    = i_cmd.sweep_rd || i_cmd.sweep_skip;
    assign fr_raddr = i_cmd.sweep_skip ? hand_inc : r_hand;

    // page table memory
    always_ff @(posedge i_clk) begin
        if (pte_we) begin
            r_pte_mem[pte_waddr] <= pte_wdata;
        end
        if (i_cmd.accept) begin
            r_pte_rd <= r_pte_mem[in_page];
        end
    end

    // per-frame memories
    always_ff @(posedge i_clk) begin
        if (do_map) begin
            r_owner_mem[map_frame] <= r_page;
        end
        if (fr_re) begin
            r_fr_owner <= r_owner_mem[fr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (do_map) begin
            r_used_mem[map_frame] <= 1'b1;
        end else if (i_cmd.hit_upd) begin
            r_used_mem[r_pte_rd[FW-1:0]] <= 1'b1;
        end else if (i_cmd.sweep_skip) begin
            r_used_mem[r_hand] <= 1'b0;
        end
        if (fr_re) begin
            r_fr_used <= r_used_mem[fr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (do_map) begin
            r_dirty_mem[map_frame] <= r_func;
        end else if (i_cmd.hit_upd && r_func) begin
            r_dirty_mem[r_pte_rd[FW-1:0]] <= 1'b1;
        end
        if (fr_re) begin
            r_fr_dirty <= r_dirty_mem[fr_raddr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page <= in_page;
            r_func <= i_s_tuser[0];
        end
        if (i_cmd.evict) begin
            r_vic_page <= r_fr_owner;
            r_vic_wb   <= r_fr_dirty;
        end
        if (out_load) begin
            unique case (1'b1)
                i_cmd.hit_upd: begin
                    r_out_data <= {r_faults, 1'b0, 8'd0, 1'b0,
                                   5'(r_pte_rd[FW-1:0]), 1'b1};
                end
                i_cmd.map_fill: begin
                    r_out_data <= {r_faults + 32'd1, 1'b0, 8'd0, 1'b0,
                                   5'(fill_frame), 1'b0};
                end
                default: begin
                    r_out_data <= {r_faults + 32'd1, r_vic_wb, 8'(r_vic_page), 1'b1,
                                   5'(r_hand), 1'b0};
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_hand      <= '0;
            r_faults    <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.map_fill) begin
                r_fill <= r_fill + 1'b1;
            end
            priority if (do_map) begin
                r_hand <= frame_inc(map_frame);
            end else if (i_cmd.sweep_skip) begin
                r_hand <= hand_inc;
            end
            if (do_map) begin
                r_faults <= r_faults + 32'd1;
            end
            r_out_valid <= (r_out_valid && !i_m_tready) || out_load;
        end
    end

    assign o_stat.in_valid = i_s_tvalid;
    assign o_stat.clr_last = (r_clr == PW'(NUM_PAGES - 1));
    assign o_stat.present  = r_pte_rd[FW];
    assign o_stat.full     = (r_fill == CW'(NUM_FRAMES));
    assign o_stat.used     = r_fr_used;
    assign o_stat.out_free = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== src/page_fault_clock_pager.sv =====
// a hit or a fault into a free frame: the page table entry is registered at accept, and the lookup
// state posts the result once the result register is free; with all frames taken, the hand sweeps
// past used frames, clearing their used bits, then evicts the first unused frame and maps into it
// a new item is accepted only after the previous one has posted its result, and the result
// register lets the next item be accepted while a result waits; reset: synchronous active low,
// then a clearing pass over all NUM_PAGES page table entries during which no item is accepted
module page_fault_clock_pager #(
    parameter int NUM_PAGES  = 256,
    parameter int NUM_FRAMES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access item
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] page
    input  logic [0:0]  i_s_tuser,   // [0] func (0 read, 1 write)
    // result item
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] hit, [5:1] frame, [6] victim_valid, [14:7] victim_page,
    // [15] writeback, [47:16] fault_total
    output logic [47:0] o_m_tdata
);

    pfcp_pkg::t_cmd  cmd;
    pfcp_pkg::t_stat stat;

    // sequencer: clearing pass, lookup, clock sweep and mapping
    pfcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_s_tready)
    );

    // page table, frame tables, hand, fill count, fault counter, result register
    pfcp_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
